FILE: rtl/ibc_pkg.sv
package ibc_pkg;

    localparam int FRACTION_BITS = 12;
    localparam int ONE           = 1 << FRACTION_BITS;

    localparam int CMD_W    = 3;
    localparam int KEY_W    = 32;
    localparam int TGT_W    = 3;
    localparam int VAL_W    = 14;
    localparam int DB_W     = 13;
    localparam int GAIN_W   = 16;
    localparam int PREV_W   = 17;
    localparam int DELTA_W  = PREV_W + 1;
    localparam int SUM_W    = 22;
    localparam int OUT_W    = 14;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int PROD_W   = DIFF_W + GAIN_W;
    localparam int SQ_W     = 2 * SUM_W;
    localparam int ROOT_W   = SUM_W;
    localparam int DIVD_W   = SUM_W + FRACTION_BITS;
    localparam int REM_W    = ROOT_W + 3;
    localparam int ITER_W   = 6;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 72;

    localparam logic signed [SUM_W-1:0]  SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] PREV_MAX    = PROD_W'(65535);
    localparam logic signed [PROD_W-1:0] PREV_MIN    = -PROD_W'(65536);
    localparam logic signed [SUM_W-1:0]  SUM_ONE     = SUM_W'(ONE);
    localparam logic signed [SUM_W-1:0]  SUM_NEG_ONE = -SUM_W'(ONE);
    localparam logic [SQ_W-1:0]          ONE_SQ      = SQ_W'(ONE * ONE);

    typedef enum logic [CMD_W-1:0] {
        CMD_BIND    = 3'd0,
        CMD_AXIS    = 3'd1,
        CMD_PRESS   = 3'd2,
        CMD_RELEASE = 3'd3,
        CMD_TICK    = 3'd4,
        CMD_UPDATE  = 3'd5
    } ibc_cmd_t;

    typedef enum logic [1:0] {
        CH_ENTRY,
        CH_X,
        CH_Y,
        CH_FIRE
    } ibc_chan_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_RD,
        S_CHK,
        S_AX_MUL,
        S_AX_SC,
        S_SUM_RD,
        S_SUM_WR,
        S_BIND_WR,
        S_U_RDX,
        S_U_RDY,
        S_U_SQX,
        S_U_SQY,
        S_U_CMP,
        S_U_ROOT,
        S_U_ROOTW,
        S_U_DX,
        S_U_DXW,
        S_U_DY,
        S_U_DYW,
        S_U_FRD,
        S_U_FCL,
        S_FIN
    } ibc_state_t;

    typedef struct packed {
        logic          load;
        logic          ent_rd;
        logic          idx_inc;
        logic          scan_rec;
        logic          bind_wr;
        logic          set_rel;
        logic          clr_rel;
        logic          mul_ax;
        logic          ax_ld;
        logic          press_ld;
        logic          tick_ld;
        logic          sum_rd;
        ibc_chan_sel_t chan_sel;
        logic          sum_wr;
        logic          x_ld;
        logic          y_ld;
        logic          sq_x;
        logic          sq_sum;
        logic          pass_ld;
        logic          root_go;
        logic          root_ld;
        logic          div_go;
        logic          div_y;
        logic          res_ld;
        logic          pair_inc;
        logic          fire_ld;
        logic          out_load;
    } ibc_dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             tgt_ok;
        logic             hit;
        logic             valid_cur;
        logic             pressed_cur;
        logic             released_cur;
        logic             idx_last;
        logic             pair_last;
        logic             big;
        logic             iter_busy;
        logic             iter_done;
        logic             out_busy;
    } ibc_dp_stat_t;

endpackage

FILE: rtl/ibc_iter.sv
module ibc_iter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       root_go,
    input  logic                       div_go,
    input  logic [ibc_pkg::SQ_W-1:0]   radicand,
    input  logic [ibc_pkg::DIVD_W-1:0] dividend,
    input  logic [ibc_pkg::ROOT_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [ibc_pkg::DIVD_W-1:0] result
);
    import ibc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic              root_mode_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [SQ_W-1:0]   work_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] q_reg;
    logic [ROOT_W-1:0] divisor_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // Square root brings down two radicand bits a step, division one.
    always_comb begin
        if (root_mode_reg) begin
            rem_sh = {rem_reg[REM_W-3:0], work_reg[SQ_W-1:SQ_W-2]};
            trial  = {q_reg[REM_W-3:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[REM_W-2:0], work_reg[SQ_W-1]};
            trial  = REM_W'(divisor_reg);
        end
        take = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (root_go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_W'(ROOT_W);
            end else if (div_go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ITER_W'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (root_go) begin
            root_mode_reg <= 1'b1;
            work_reg      <= radicand;
            rem_reg       <= '0;
            q_reg         <= '0;
        end else if (div_go) begin
            root_mode_reg <= 1'b0;
            work_reg      <= {dividend, {(SQ_W-DIVD_W){1'b0}}};
            rem_reg       <= '0;
            q_reg         <= '0;
            divisor_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? (rem_sh - trial) : rem_sh;
            q_reg   <= {q_reg[DIVD_W-2:0], take};
            if (root_mode_reg) begin
                work_reg <= {work_reg[SQ_W-3:0], 2'b00};
            end else begin
                work_reg <= {work_reg[SQ_W-2:0], 1'b0};
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = q_reg;

endmodule

FILE: rtl/ibc_datapath.sv
module ibc_datapath #(
    parameter int TABLE_ENTRIES    = 16,
    parameter int LOGICAL_CHANNELS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ibc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [ibc_pkg::CMD_W-1:0]     s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ibc_pkg::M_TDATA_W-1:0] m_tdata,
    input  ibc_pkg::ibc_dp_cmd_t          cmd,
    output ibc_pkg::ibc_dp_stat_t         stat
);
    import ibc_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CH_W  = $clog2(LOGICAL_CHANNELS);

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [TGT_W-1:0]         tgt;
        logic [DB_W-1:0]          db;
        logic signed [GAIN_W-1:0] gain;
        logic signed [PREV_W-1:0] prev;
    } ent_t;

    // Item fields.
    logic [CMD_W-1:0]         cmd_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [TGT_W-1:0]         tgt_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic [DB_W-1:0]          db_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    // Binding table: payload in a memory, flags in flip-flops.
    ent_t                     ent_mem [TABLE_ENTRIES];
    ent_t                     ent_q;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] pressed_reg;
    logic [TABLE_ENTRIES-1:0] released_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     match_found_reg;
    logic [IDX_W-1:0]         match_idx_reg;
    logic                     free_found_reg;
    logic [IDX_W-1:0]         free_idx_reg;

    // Channel sums: memory plus a written bit per channel, unwritten reads as zero.
    logic signed [SUM_W-1:0]     sum_mem [LOGICAL_CHANNELS];
    logic [LOGICAL_CHANNELS-1:0] sum_ok_reg;
    logic signed [SUM_W-1:0]     sum_q;
    logic                        sum_hit_q;
    logic signed [SUM_W-1:0]     sum_val;
    logic [CH_W-1:0]             chan_reg;
    logic [CH_W-1:0]             rd_addr;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [PREV_W-1:0]  new_prev_reg;
    logic                      status_reg;

    logic signed [SUM_W-1:0] x_reg;
    logic signed [SUM_W-1:0] y_reg;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         s_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic                    pair_reg;
    logic [OUT_W-1:0]        res_reg [4];
    logic [OUT_W-1:0]        fire_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                      hit;
    logic signed [DIFF_W-1:0]  v_e;
    logic signed [DIFF_W-1:0]  d_e;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  diff_w;
    logic signed [PROD_W-1:0]  gain_w;
    logic signed [PROD_W-1:0]  sh;
    logic signed [PREV_W-1:0]  sc;
    logic signed [SUM_W:0]     sum_ext;
    logic signed [SUM_W-1:0]   sum_new;
    logic [SQ_W-1:0]           sq_x;
    logic [SQ_W-1:0]           sq_y;
    logic                      div_neg;
    logic [SUM_W-1:0]          div_mag;
    logic [DIVD_W-1:0]         dividend;
    logic [DIVD_W-1:0]         iter_result;
    logic                      iter_busy;
    logic                      iter_done;
    logic [OUT_W-1:0]          quot;
    logic [OUT_W-1:0]          quot_signed;
    logic signed [SUM_W-1:0]   fire_cl;
    logic [IDX_W-1:0]          slot;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    ent_t                      wr_data;

    assign hit     = valid_reg[idx_reg] && (ent_q.key == key_reg);
    assign sum_val = sum_hit_q ? sum_q : '0;

    // Deadzone and gain.
    always_comb begin
        v_e = DIFF_W'(val_reg);
        d_e = DIFF_W'(signed'({1'b0, ent_q.db}));
        if (v_e > d_e) begin
            diff = v_e - d_e;
        end else if (v_e < -d_e) begin
            diff = v_e + d_e;
        end else begin
            diff = '0;
        end
        diff_w = PROD_W'(diff);
        gain_w = PROD_W'(ent_q.gain);
        sh     = prod_reg >>> FRACTION_BITS;
        if (sh > PREV_MAX) begin
            sc = PREV_MAX[PREV_W-1:0];
        end else if (sh < PREV_MIN) begin
            sc = PREV_MIN[PREV_W-1:0];
        end else begin
            sc = sh[PREV_W-1:0];
        end
    end

    always_comb begin
        sum_ext = (SUM_W+1)'(sum_val) + (SUM_W+1)'(delta_reg);
        if (sum_ext > (SUM_W+1)'(SUM_MAX)) begin
            sum_new = SUM_MAX;
        end else if (sum_ext < (SUM_W+1)'(SUM_MIN)) begin
            sum_new = SUM_MIN;
        end else begin
            sum_new = sum_ext[SUM_W-1:0];
        end
    end

    always_comb begin
        case (cmd.chan_sel)
            CH_X:    rd_addr = CH_W'({pair_reg, 1'b0});
            CH_Y:    rd_addr = CH_W'({pair_reg, 1'b1});
            CH_FIRE: rd_addr = CH_W'(4);
            default: rd_addr = chan_reg;
        endcase
    end

    always_comb begin
        sq_x        = SQ_W'(x_reg) * SQ_W'(x_reg);
        sq_y        = SQ_W'(y_reg) * SQ_W'(y_reg);
        div_neg     = cmd.div_y ? y_reg[SUM_W-1] : x_reg[SUM_W-1];
        div_mag     = cmd.div_y ? SUM_W'(div_neg ? -y_reg : y_reg)
                                : SUM_W'(div_neg ? -x_reg : x_reg);
        dividend    = {div_mag, {FRACTION_BITS{1'b0}}};
        quot        = iter_result[OUT_W-1:0];
        quot_signed = cmd.div_y ? (y_reg[SUM_W-1] ? -quot : quot)
                                : (x_reg[SUM_W-1] ? -quot : quot);
        if (sum_val > SUM_ONE) begin
            fire_cl = SUM_ONE;
        end else if (sum_val < SUM_NEG_ONE) begin
            fire_cl = SUM_NEG_ONE;
        end else begin
            fire_cl = sum_val;
        end
    end

    // Single write port of the table memory: bind, or the new sample of an axis.
    always_comb begin
        slot    = match_found_reg ? match_idx_reg : free_idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = ent_q;
        if (cmd.bind_wr && (match_found_reg || free_found_reg)) begin
            wr_en   = 1'b1;
            wr_addr = slot;
            wr_data = '{key: key_reg, tgt: tgt_reg, db: db_reg, gain: gain_reg, prev: '0};
        end else if (cmd.sum_wr && (cmd_reg == CMD_AXIS)) begin
            wr_en        = 1'b1;
            wr_data.prev = new_prev_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ent_mem[wr_addr] <= wr_data;
        end
        if (cmd.ent_rd) begin
            ent_q <= ent_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_wr) begin
            sum_mem[chan_reg] <= sum_new;
        end
        if (cmd.sum_rd) begin
            sum_q     <= sum_mem[rd_addr];
            sum_hit_q <= sum_ok_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            pressed_reg     <= '0;
            released_reg    <= '0;
            sum_ok_reg      <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
            end
            if (cmd.scan_rec) begin
                if (!match_found_reg && hit && (ent_q.tgt == tgt_reg)) begin
                    match_found_reg <= 1'b1;
                end
                if (!free_found_reg && !valid_reg[idx_reg]) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.bind_wr && (match_found_reg || free_found_reg)) begin
                valid_reg[slot]    <= 1'b1;
                pressed_reg[slot]  <= 1'b0;
                released_reg[slot] <= 1'b0;
            end
            if (cmd.set_rel) begin
                released_reg[idx_reg] <= 1'b1;
            end
            if (cmd.clr_rel) begin
                released_reg[idx_reg] <= 1'b0;
            end
            if (cmd.sum_wr) begin
                sum_ok_reg[chan_reg] <= 1'b1;
                if (cmd_reg == CMD_PRESS) begin
                    pressed_reg[idx_reg] <= 1'b1;
                end
                if (cmd_reg == CMD_TICK) begin
                    pressed_reg[idx_reg]  <= 1'b0;
                    released_reg[idx_reg] <= 1'b0;
                end
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= s_tuser;
            key_reg    <= {s_tdata[7:0], s_tdata[15:8], s_tdata[31:16]};
            tgt_reg    <= s_tdata[34:32];
            val_reg    <= s_tdata[48:35];
            db_reg     <= s_tdata[61:49];
            gain_reg   <= s_tdata[77:62];
            idx_reg    <= '0;
            pair_reg   <= 1'b0;
            status_reg <= 1'b0;
            fire_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                res_reg[i] <= '0;
            end
        end
        if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.scan_rec) begin
            if (!match_found_reg && hit && (ent_q.tgt == tgt_reg)) begin
                match_idx_reg <= idx_reg;
            end
            if (!free_found_reg && !valid_reg[idx_reg]) begin
                free_idx_reg <= idx_reg;
            end
        end
        if (cmd.bind_wr && !(match_found_reg || free_found_reg)) begin
            status_reg <= 1'b1;
        end
        if (cmd.mul_ax) begin
            prod_reg <= diff_w * gain_w;
        end
        if (cmd.ax_ld) begin
            delta_reg    <= DELTA_W'(sc) - DELTA_W'(ent_q.prev);
            new_prev_reg <= sc;
            chan_reg     <= CH_W'(ent_q.tgt);
        end
        if (cmd.press_ld) begin
            delta_reg <= DELTA_W'(ent_q.gain);
            chan_reg  <= CH_W'(ent_q.tgt);
        end
        if (cmd.tick_ld) begin
            delta_reg <= -DELTA_W'(ent_q.gain);
            chan_reg  <= CH_W'(ent_q.tgt);
        end
        if (cmd.x_ld) begin
            x_reg <= sum_val;
        end
        if (cmd.y_ld) begin
            y_reg <= sum_val;
        end
        if (cmd.sq_x) begin
            sqx_reg <= sq_x;
        end
        if (cmd.sq_sum) begin
            s_reg <= sqx_reg + sq_y;
        end
        if (cmd.pass_ld) begin
            res_reg[{pair_reg, 1'b0}] <= x_reg[OUT_W-1:0];
            res_reg[{pair_reg, 1'b1}] <= y_reg[OUT_W-1:0];
        end
        if (cmd.root_ld) begin
            root_reg <= iter_result[ROOT_W-1:0];
        end
        if (cmd.res_ld) begin
            res_reg[{pair_reg, cmd.div_y}] <= quot_signed;
        end
        if (cmd.pair_inc) begin
            pair_reg <= 1'b1;
        end
        if (cmd.fire_ld) begin
            fire_reg <= fire_cl[OUT_W-1:0];
        end
        if (cmd.out_load) begin
            out_data_reg <= {1'b0, fire_reg, res_reg[3], res_reg[2], res_reg[1], res_reg[0],
                             status_reg};
        end
    end

    ibc_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .root_go  (cmd.root_go),
        .div_go   (cmd.div_go),
        .radicand (s_reg),
        .dividend (dividend),
        .divisor  (root_reg),
        .busy     (iter_busy),
        .done     (iter_done),
        .result   (iter_result)
    );

    always_comb begin
        stat.cmd          = cmd_reg;
        stat.tgt_ok       = (int'(tgt_reg) < LOGICAL_CHANNELS);
        stat.hit          = hit;
        stat.valid_cur    = valid_reg[idx_reg];
        stat.pressed_cur  = pressed_reg[idx_reg];
        stat.released_cur = released_reg[idx_reg];
        stat.idx_last     = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
        stat.pair_last    = pair_reg;
        stat.big          = (s_reg > ONE_SQ);
        stat.iter_busy    = iter_busy;
        stat.iter_done    = iter_done;
        stat.out_busy     = out_valid_reg && !m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/ibc_ctrl.sv
module ibc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ibc_pkg::ibc_dp_stat_t stat,
    output ibc_pkg::ibc_dp_cmd_t  cmd
);
    import ibc_pkg::*;

    ibc_state_t state_reg;
    ibc_state_t state_next;
    ibc_state_t scan_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign scan_next = stat.idx_last ? S_FIN : S_RD;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.cmd)
                    CMD_BIND:    state_next = stat.tgt_ok ? S_RD : S_FIN;
                    CMD_AXIS:    state_next = S_RD;
                    CMD_PRESS:   state_next = S_RD;
                    CMD_RELEASE: state_next = S_RD;
                    CMD_TICK:    state_next = S_RD;
                    CMD_UPDATE:  state_next = S_U_RDX;
                    default:     state_next = S_FIN;
                endcase
            end
            S_RD: state_next = S_CHK;
            S_CHK: begin
                case (stat.cmd)
                    CMD_BIND: state_next = stat.idx_last ? S_BIND_WR : S_RD;
                    CMD_AXIS: state_next = stat.hit ? S_AX_MUL : scan_next;
                    CMD_PRESS: begin
                        state_next = (stat.hit && !stat.pressed_cur) ? S_SUM_RD : scan_next;
                    end
                    CMD_TICK: begin
                        if (stat.valid_cur && stat.released_cur && stat.pressed_cur) begin
                            state_next = S_SUM_RD;
                        end else begin
                            state_next = scan_next;
                        end
                    end
                    default: state_next = scan_next;
                endcase
            end
            S_AX_MUL:  state_next = S_AX_SC;
            S_AX_SC:   state_next = S_SUM_RD;
            S_SUM_RD:  state_next = S_SUM_WR;
            S_SUM_WR:  state_next = scan_next;
            S_BIND_WR: state_next = S_FIN;
            S_U_RDX:   state_next = S_U_RDY;
            S_U_RDY:   state_next = S_U_SQX;
            S_U_SQX:   state_next = S_U_SQY;
            S_U_SQY:   state_next = S_U_CMP;
            S_U_CMP: begin
                if (stat.big) begin
                    state_next = S_U_ROOT;
                end else begin
                    state_next = stat.pair_last ? S_U_FRD : S_U_RDX;
                end
            end
            S_U_ROOT: state_next = S_U_ROOTW;
            S_U_ROOTW: begin
                if (stat.iter_done) begin
                    state_next = S_U_DX;
                end
            end
            S_U_DX: state_next = S_U_DXW;
            S_U_DXW: begin
                if (stat.iter_done) begin
                    state_next = S_U_DY;
                end
            end
            S_U_DY: state_next = S_U_DYW;
            S_U_DYW: begin
                if (stat.iter_done) begin
                    state_next = stat.pair_last ? S_U_FRD : S_U_RDX;
                end
            end
            S_U_FRD: state_next = S_U_FCL;
            S_U_FCL: state_next = S_FIN;
            S_FIN: begin
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_RD: cmd.ent_rd = 1'b1;
            S_CHK: begin
                case (stat.cmd)
                    CMD_BIND: begin
                        cmd.scan_rec = 1'b1;
                        cmd.idx_inc  = !stat.idx_last;
                    end
                    CMD_AXIS: cmd.idx_inc = !stat.hit && !stat.idx_last;
                    CMD_PRESS: begin
                        if (stat.hit && !stat.pressed_cur) begin
                            cmd.press_ld = 1'b1;
                        end else begin
                            cmd.idx_inc = !stat.idx_last;
                        end
                    end
                    CMD_RELEASE: begin
                        cmd.set_rel = stat.hit;
                        cmd.idx_inc = !stat.idx_last;
                    end
                    CMD_TICK: begin
                        if (stat.valid_cur && stat.released_cur && stat.pressed_cur) begin
                            cmd.tick_ld = 1'b1;
                        end else begin
                            cmd.clr_rel = stat.valid_cur && stat.released_cur;
                            cmd.idx_inc = !stat.idx_last;
                        end
                    end
                    default: cmd.idx_inc = !stat.idx_last;
                endcase
            end
            S_AX_MUL: cmd.mul_ax = 1'b1;
            S_AX_SC:  cmd.ax_ld  = 1'b1;
            S_SUM_RD: begin
                cmd.sum_rd   = 1'b1;
                cmd.chan_sel = CH_ENTRY;
            end
            S_SUM_WR: begin
                cmd.sum_wr  = 1'b1;
                cmd.idx_inc = !stat.idx_last;
            end
            S_BIND_WR: cmd.bind_wr = 1'b1;
            S_U_RDX: begin
                cmd.sum_rd   = 1'b1;
                cmd.chan_sel = CH_X;
            end
            S_U_RDY: begin
                cmd.x_ld     = 1'b1;
                cmd.sum_rd   = 1'b1;
                cmd.chan_sel = CH_Y;
            end
            S_U_SQX: begin
                cmd.y_ld = 1'b1;
                cmd.sq_x = 1'b1;
            end
            S_U_SQY: cmd.sq_sum = 1'b1;
            S_U_CMP: begin
                cmd.pass_ld  = !stat.big;
                cmd.pair_inc = !stat.big && !stat.pair_last;
            end
            S_U_ROOT:  cmd.root_go = 1'b1;
            S_U_ROOTW: cmd.root_ld = stat.iter_done;
            S_U_DX:    cmd.div_go  = 1'b1;
            S_U_DXW:   cmd.res_ld  = stat.iter_done;
            S_U_DY: begin
                cmd.div_go = 1'b1;
                cmd.div_y  = 1'b1;
            end
            S_U_DYW: begin
                cmd.div_y    = 1'b1;
                cmd.res_ld   = stat.iter_done;
                cmd.pair_inc = stat.iter_done && !stat.pair_last;
            end
            S_U_FRD: begin
                cmd.sum_rd   = 1'b1;
                cmd.chan_sel = CH_FIRE;
            end
            S_U_FCL: cmd.fire_ld  = 1'b1;
            S_FIN:   cmd.out_load = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

FILE: rtl/input_binding_conditioner_core.sv
// Channel  Direction  Ports                        Contents
// s_       in         s_tvalid s_tready s_tdata    one event, command in s_tuser
//                     s_tuser
// m_       out        m_tvalid m_tready m_tdata    one result per event
//
// Every event passes through accept, dispatch and result hand-over.
// Table events (bind with a valid target, axis, press, release, tick) walk every table
// entry, with extra steps for each entry an axis, press or tick acts upon, and a bind
// write at the end for bind. Update passes each vector pair within unit length as it
// is and scales each longer pair by the serial root and the two serial divides, then
// reads and clamps fire.
// Reset is synchronous; the table flags and channel sums clear at once, no sweep.
// A stalled m_ side holds the finished result while the next event is accepted.
module input_binding_conditioner_core #(
    parameter int TABLE_ENTRIES    = 16,
    parameter int LOGICAL_CHANNELS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // control_type, device, control, target, axis_value, dead_band, gain
    input  logic [ibc_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [ibc_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, move_x, move_y, aim_x, aim_y, fire_level
    output logic [ibc_pkg::M_TDATA_W-1:0] m_tdata
);
    import ibc_pkg::*;

    ibc_dp_cmd_t  dp_cmd;
    ibc_dp_stat_t dp_stat;

    ibc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    ibc_datapath #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .LOGICAL_CHANNELS (LOGICAL_CHANNELS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    // One event at a time: after a transaction in, the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an event is in progress");

    // A finished result never overwrites one still waiting on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |-> !(m_tvalid && !m_tready))
        else $error("pending result overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.out_load |=> m_tvalid)
        else $error("result loaded but not presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.root_go || dp_cmd.div_go) |-> !dp_stat.iter_busy)
        else $error("serial unit started while busy");

endmodule
